>>> rtl/eav_pkg.sv
package eav_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned PartWidth  = 7;

  // part limits
  localparam logic [PartWidth-1:0] LocalMax = 7'd64;
  localparam logic [PartWidth-1:0] LabelMax = 7'd63;
  localparam logic [PartWidth-1:0] TldMin   = 7'd2;

  localparam logic [CountWidth-1:0] CountSat = 8'hFF;
  localparam logic [CountWidth-1:0] MaxLenRst = 8'd255;

  // byte codes
  localparam logic [CharWidth-1:0] ChSpace  = 8'h20;
  localparam logic [CharWidth-1:0] ChDel    = 8'h7F;
  localparam logic [CharWidth-1:0] ChAt     = 8'h40;
  localparam logic [CharWidth-1:0] ChDot    = 8'h2E;
  localparam logic [CharWidth-1:0] ChHyphen = 8'h2D;
  localparam logic [CharWidth-1:0] CaseBit  = 8'h20;

  typedef struct packed {
    logic is_ctrl;
    logic is_at;
    logic is_dot;
    logic is_hyphen;
    logic is_upper;
    logic local_ok;
    logic domain_ok;
  } char_class_t;

endpackage

>>> rtl/eav_char_class.sv
module eav_char_class (
  input  logic [eav_pkg::CharWidth-1:0] char_i,
  output eav_pkg::char_class_t          class_o
);

  logic upper, lower, digit, alnum, special;

  assign upper = (char_i >= 8'h41) && (char_i <= 8'h5A);
  assign lower = (char_i >= 8'h61) && (char_i <= 8'h7A);
  assign digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign alnum = upper || lower || digit;

  // ! # $ % & ' * + / = ? ^ _ ` { | } ~ .
  always_comb begin
    case (char_i)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2F,
      8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E,
      8'h2E: special = 1'b1;
      default: special = 1'b0;
    endcase
  end

  assign class_o.is_ctrl   = (char_i <= eav_pkg::ChSpace) || (char_i == eav_pkg::ChDel);
  assign class_o.is_at     = (char_i == eav_pkg::ChAt);
  assign class_o.is_dot    = (char_i == eav_pkg::ChDot);
  assign class_o.is_hyphen = (char_i == eav_pkg::ChHyphen);
  assign class_o.is_upper  = upper;
  assign class_o.local_ok  = alnum || special;
  assign class_o.domain_ok = alnum || class_o.is_hyphen || class_o.is_dot;

endmodule

>>> rtl/email_address_validator.sv
// pipeline: an accepted input beat passes the input register, then the result register,
//   to its result beat; throughput: one beat per cycle while the result side is not
//   stalled; the per-byte state update is a handful of flags and three small counters
// reset: asynchronous, active low; clears all parse state and both pipeline stages,
//   max_len returns to 255; parse state clears again after every last beat
module email_address_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_len
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // is_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] char_out, [15:8] length
  output logic        m_axis_tlast,   // done_res
  output logic        m_axis_tuser    // valid_res
);

  // config register, to be written only while idle; the block itself does not enforce this
  logic [eav_pkg::CountWidth-1:0] max_len_q;

  // input register stage
  logic                          in_valid_q;
  logic [eav_pkg::CharWidth-1:0] in_char_q;
  logic                          in_last_q;

  // parse state
  logic [eav_pkg::CountWidth-1:0] byte_count_q, byte_count_d;
  logic                           in_domain_q, in_domain_d;
  logic [eav_pkg::PartWidth-1:0]  local_count_q, local_count_d;
  logic [eav_pkg::PartWidth-1:0]  label_count_q, label_count_d;
  logic                           prev_dot_q, prev_dot_d;
  logic                           prev_hyphen_q, prev_hyphen_d;
  logic                           seen_dot_q, seen_dot_d;
  logic                           failed_q, failed_d;

  // result register stage
  logic                           out_valid_q;
  logic [eav_pkg::CharWidth-1:0]  out_char_q, out_char_d;
  logic [eav_pkg::CountWidth-1:0] out_len_q, out_len_d;
  logic                           out_done_q;
  logic                           out_ok_q, out_ok_d;

  eav_pkg::char_class_t cls;

  logic advance;   // input stage moves into the result stage
  logic in_take;
  logic ok;

  assign cfg_ready_o = 1'b1;

  // result stage frees when empty or its beat is taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  eav_char_class u_class (
    .char_i  (in_char_q),
    .class_o (cls)
  );

  // one byte of parsing
  always_comb begin
    byte_count_d  = (byte_count_q != eav_pkg::CountSat) ?
                    byte_count_q + eav_pkg::CountWidth'(1) : byte_count_q;
    in_domain_d   = in_domain_q;
    local_count_d = local_count_q;
    label_count_d = label_count_q;
    prev_dot_d    = prev_dot_q;
    prev_hyphen_d = prev_hyphen_q;
    seen_dot_d    = seen_dot_q;
    failed_d      = failed_q || cls.is_ctrl;
    out_char_d    = in_char_q;

    if (!in_domain_q) begin
      if (cls.is_at) begin
        // local part must be non-empty and not end in a dot
        if ((local_count_q == '0) || prev_dot_q) failed_d = 1'b1;
        in_domain_d   = 1'b1;
        prev_dot_d    = 1'b0;
        prev_hyphen_d = 1'b0;
      end else begin
        if (!cls.local_ok) failed_d = 1'b1;
        // no leading or doubled dot
        if (cls.is_dot && ((local_count_q == '0) || prev_dot_q)) failed_d = 1'b1;
        prev_dot_d = cls.is_dot;
        if (local_count_q >= eav_pkg::LocalMax) begin
          failed_d = 1'b1;
        end else begin
          local_count_d = local_count_q + eav_pkg::PartWidth'(1);
        end
      end
    end else begin
      if (cls.is_upper) out_char_d = in_char_q + eav_pkg::CaseBit;
      if (!cls.domain_ok) failed_d = 1'b1;
      if (cls.is_dot) begin
        // label closes: must be non-empty and not end in a hyphen
        seen_dot_d = 1'b1;
        if ((label_count_q == '0) || prev_hyphen_q) failed_d = 1'b1;
        label_count_d = '0;
        prev_hyphen_d = 1'b0;
      end else begin
        if ((label_count_q == '0) && cls.is_hyphen) failed_d = 1'b1;
        if (label_count_q >= eav_pkg::LabelMax) begin
          failed_d = 1'b1;
        end else begin
          label_count_d = label_count_q + eav_pkg::PartWidth'(1);
        end
        prev_hyphen_d = cls.is_hyphen;
      end
    end

    // final verdict on the updated state
    ok = !failed_d && in_domain_d && seen_dot_d && !prev_hyphen_d &&
         (label_count_d >= eav_pkg::TldMin) && (byte_count_d < max_len_q);

    out_ok_d  = in_last_q && ok;
    out_len_d = in_last_q ? byte_count_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q     <= eav_pkg::MaxLenRst;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_done_q    <= 1'b0;
      byte_count_q  <= '0;
      in_domain_q   <= 1'b0;
      local_count_q <= '0;
      label_count_q <= '0;
      prev_dot_q    <= 1'b0;
      prev_hyphen_q <= 1'b0;
      seen_dot_q    <= 1'b0;
      failed_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) max_len_q <= cfg_data_i;

      if (s_axis_tready) in_valid_q <= s_axis_tvalid;

      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) out_done_q <= in_last_q;
      end

      if (advance && in_valid_q) begin
        if (in_last_q) begin
          // address finished, start over
          byte_count_q  <= '0;
          in_domain_q   <= 1'b0;
          local_count_q <= '0;
          label_count_q <= '0;
          prev_dot_q    <= 1'b0;
          prev_hyphen_q <= 1'b0;
          seen_dot_q    <= 1'b0;
          failed_q      <= 1'b0;
        end else begin
          byte_count_q  <= byte_count_d;
          in_domain_q   <= in_domain_d;
          local_count_q <= local_count_d;
          label_count_q <= label_count_d;
          prev_dot_q    <= prev_dot_d;
          prev_hyphen_q <= prev_hyphen_d;
          seen_dot_q    <= seen_dot_d;
          failed_q      <= failed_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_valid_q) begin
      out_char_q <= out_char_d;
      out_len_q  <= out_len_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_char_q};
  assign m_axis_tlast  = out_done_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

>>> rtl/eav_checker.sv
module eav_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // verdict and length only on the last beat of an address
  a_mid_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser && (m_axis_tdata[15:8] == 8'd0))
    else $error("verdict or length on a non-final beat");

  // shortest passing address is six bytes
  a_valid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:8] >= 8'd6)
    else $error("address passed with impossible length");

  // input backs up only when the result side stalls
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while result side free");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

endmodule

bind email_address_validator eav_checker u_eav_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
